### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AST_ASSERT(lbl, prop, msg) `AST_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define AST_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define AST_ASSERT(lbl, prop, msg)
`endif
`endif

### hdl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// Types and constants shared by the audible state tracker modules.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int MARGIN_BITS = 23;
    localparam int MCF_BITS    = 20;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 23;

    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 23'd839;
    localparam logic [MCF_BITS-1:0]    MCF_RESET    = 20'd4096;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_MARGIN = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CHANGE    = 1'b1;

    localparam logic [1:0] CMD_OTHER = 2'd0;
    localparam logic [1:0] CMD_MUSIC = 2'd1;
    localparam logic [1:0] CMD_MIX   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] CODE_SILENT       = 2'd0;
    localparam logic [1:0] CODE_SILENT_MUSIC = 2'd1;
    localparam logic [1:0] CODE_AUDIBLE      = 2'd2;

    typedef enum logic [2:0] {
        ST_SILENT       = 3'b001,
        ST_SILENT_MUSIC = 3'b010,
        ST_AUDIBLE      = 3'b100
    } dev_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
        logic       first;
        logic       last;
    } frame_ctrl_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] state;
        logic       changed;
    } result_t;

    function automatic logic [1:0] encode_state(dev_state_t s);
        logic [1:0] code;
        unique case (s)
            ST_SILENT:       code = CODE_SILENT;
            ST_SILENT_MUSIC: code = CODE_SILENT_MUSIC;
            ST_AUDIBLE:      code = CODE_AUDIBLE;
            default:         code = CODE_SILENT;
        endcase
        return code;
    endfunction

endpackage

### hdl/ast_in_stage.sv
// ----------------------------------------------------------------------------
// ast_in_stage
// Input register: holds one frame beat until the core can take it.
// ----------------------------------------------------------------------------
module ast_in_stage #(
    parameter int TIME_BITS   = 48,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic [TIME_BITS-1:0]          frame_time,
    input  logic                          first_frame,
    input  logic                          last_frame,
    input  logic                          advance,
    output ast_pkg::frame_ctrl_t          ctrl,
    output logic signed [SAMPLE_BITS-1:0] left_q,
    output logic signed [SAMPLE_BITS-1:0] right_q,
    output logic [TIME_BITS-1:0]          time_q
);
    import ast_pkg::*;

    logic                          vld_reg;
    logic [1:0]                    cmd_reg;
    logic                          first_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic [TIME_BITS-1:0]          time_reg;

    assign in_stall = vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg   <= cmd;
            first_reg <= first_frame;
            last_reg  <= last_frame;
            left_reg  <= left_sample;
            right_reg <= right_sample;
            time_reg  <= frame_time;
        end
    end

    always_comb
    begin
        ctrl.valid = vld_reg;
        ctrl.cmd   = cmd_reg;
        ctrl.first = first_reg;
        ctrl.last  = last_reg;
    end

    assign left_q  = left_reg;
    assign right_q = right_reg;
    assign time_q  = time_reg;

endmodule

### hdl/ast_core.sv
// ----------------------------------------------------------------------------
// ast_core
// Buffer audibility, latest-time bookkeeping and the three-state machine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ast_core #(
    parameter int TIME_BITS   = 48,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  ast_pkg::frame_ctrl_t             ctrl,
    input  logic signed [SAMPLE_BITS-1:0]    left_sample,
    input  logic signed [SAMPLE_BITS-1:0]    right_sample,
    input  logic [TIME_BITS-1:0]             frame_time,
    input  logic [ast_pkg::MARGIN_BITS-1:0]  sample_margin,
    input  logic [ast_pkg::MCF_BITS-1:0]     min_change_frames,
    output ast_pkg::result_t                 res
);
    import ast_pkg::*;

    localparam int DW = ((SAMPLE_BITS + 1 > MARGIN_BITS + 1) ? SAMPLE_BITS + 1
                                                              : MARGIN_BITS + 1) + 1;
    localparam int TW = TIME_BITS + 1;

    dev_state_t                    state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] first_l_reg, first_l_next;
    logic signed [SAMPLE_BITS-1:0] first_r_reg, first_r_next;
    logic                          buf_aud_reg, buf_aud_next;
    logic [TIME_BITS-1:0]          ts_reg, ts_next;
    logic [TIME_BITS-1:0]          tsm_reg, tsm_next;
    logic [TIME_BITS-1:0]          tam_reg, tam_next;
    logic [TIME_BITS-1:0]          tao_reg, tao_next;

    logic                          fire;
    logic signed [SAMPLE_BITS-1:0] ref_l, ref_r;
    logic signed [DW-1:0]          dl, dr, mg;
    logic                          aud_now;
    logic [TIME_BITS-1:0]          ts_upd;
    logic signed [TW-1:0]          mc, d_sil, d_msil, d_aud, d_maud;
    logic                          c_aud, c_mus, c_sil;
    logic                          mix_end;

    assign fire = advance && ctrl.valid;

    // a first frame compares against itself, so it never deviates
    assign ref_l = ctrl.first ? left_sample  : first_l_reg;
    assign ref_r = ctrl.first ? right_sample : first_r_reg;

    assign dl = $signed({{(DW-SAMPLE_BITS){left_sample[SAMPLE_BITS-1]}}, left_sample})
              - $signed({{(DW-SAMPLE_BITS){ref_l[SAMPLE_BITS-1]}}, ref_l});
    assign dr = $signed({{(DW-SAMPLE_BITS){right_sample[SAMPLE_BITS-1]}}, right_sample})
              - $signed({{(DW-SAMPLE_BITS){ref_r[SAMPLE_BITS-1]}}, ref_r});
    assign mg = $signed({{(DW-MARGIN_BITS){1'b0}}, sample_margin});

    assign aud_now = (!ctrl.first && buf_aud_reg)
                   || (dl > mg) || (dl < -mg) || (dr > mg) || (dr < -mg);

    assign mix_end = ctrl.cmd == CMD_MIX && ctrl.last;

    // silent mix buffer raises its latest time before the state is evaluated
    assign ts_upd = (mix_end && !aud_now && frame_time > ts_reg) ? frame_time : ts_reg;

    assign mc     = $signed({{(TW-MCF_BITS){1'b0}}, min_change_frames});
    assign d_sil  = $signed({1'b0, frame_time}) - $signed({1'b0, ts_upd});
    assign d_msil = $signed({1'b0, frame_time}) - $signed({1'b0, tsm_reg});
    assign d_aud  = $signed({1'b0, frame_time}) - $signed({1'b0, tao_reg});
    assign d_maud = $signed({1'b0, frame_time}) - $signed({1'b0, tam_reg});

    assign c_aud = state_reg != ST_AUDIBLE && d_sil >= mc && d_aud <= 0 && tao_reg != '0;
    assign c_mus = ((state_reg == ST_SILENT && d_msil >= mc)
                   || (state_reg == ST_AUDIBLE && d_aud >= mc && d_msil >= mc))
                   && d_maud <= 0 && tam_reg != '0;
    assign c_sil = state_reg != ST_SILENT && d_aud >= mc && d_maud >= mc;

    always_comb
    begin
        state_next   = state_reg;
        first_l_next = first_l_reg;
        first_r_next = first_r_reg;
        buf_aud_next = buf_aud_reg;
        ts_next      = ts_reg;
        tsm_next     = tsm_reg;
        tam_next     = tam_reg;
        tao_next     = tao_reg;
        res.valid    = 1'b0;
        res.changed  = 1'b0;
        if (fire)
        begin
            if (ctrl.cmd == CMD_CLEAR)
            begin
                state_next   = ST_SILENT;
                first_l_next = '0;
                first_r_next = '0;
                buf_aud_next = 1'b0;
                ts_next      = '0;
                tsm_next     = '0;
                tam_next     = '0;
                tao_next     = '0;
            end
            else
            begin
                first_l_next = ref_l;
                first_r_next = ref_r;
                buf_aud_next = ctrl.last ? 1'b0 : aud_now;
                if (ctrl.last)
                begin
                    case (ctrl.cmd)
                        CMD_MUSIC:
                        begin
                            if (aud_now && frame_time > tam_reg)
                                tam_next = frame_time;
                            if (!aud_now && frame_time > tsm_reg)
                                tsm_next = frame_time;
                        end
                        CMD_OTHER:
                        begin
                            if (aud_now && frame_time > tao_reg)
                                tao_next = frame_time;
                        end
                        default:
                        begin
                            ts_next   = ts_upd;
                            res.valid = 1'b1;
                            if (c_aud)
                            begin
                                state_next  = ST_AUDIBLE;
                                res.changed = 1'b1;
                            end
                            else if (c_mus)
                            begin
                                state_next  = ST_SILENT_MUSIC;
                                res.changed = 1'b1;
                            end
                            else if (c_sil)
                            begin
                                state_next  = ST_SILENT;
                                res.changed = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
        res.state = encode_state(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SILENT;
            first_l_reg <= '0;
            first_r_reg <= '0;
            buf_aud_reg <= 1'b0;
            ts_reg      <= '0;
            tsm_reg     <= '0;
            tam_reg     <= '0;
            tao_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            first_l_reg <= first_l_next;
            first_r_reg <= first_r_next;
            buf_aud_reg <= buf_aud_next;
            ts_reg      <= ts_next;
            tsm_reg     <= tsm_next;
            tam_reg     <= tam_next;
            tao_reg     <= tao_next;
        end
    end

    `AST_ASSERT(a_clear_resets, (fire && ctrl.cmd == CMD_CLEAR) |=> (state_reg == ST_SILENT && !buf_aud_reg && tao_reg == '0 && tam_reg == '0), "clear did not reset state")
    `AST_ASSERT(a_changed_moves, (fire && res.valid && res.changed) |=> (state_reg != $past(state_reg)), "changed flag without a state move")
    `AST_ASSERT(a_state_holds, (!(fire && res.changed) && !(fire && ctrl.cmd == CMD_CLEAR)) |=> $stable(state_reg), "state moved without a reported change")

endmodule

### hdl/ast_out_stage.sv
// ----------------------------------------------------------------------------
// ast_out_stage
// Result register towards the receiver; frees the pipe when not stalled.
// ----------------------------------------------------------------------------
module ast_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  ast_pkg::result_t res,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [1:0]       audible_state,
    output logic             state_changed,
    output logic             advance
);
    import ast_pkg::*;

    logic       vld_reg;
    logic [1:0] state_reg;
    logic       changed_reg;

    assign advance = !vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            state_reg   <= res.state;
            changed_reg <= res.changed;
        end
    end

    assign out_valid     = vld_reg;
    assign audible_state = state_reg;
    assign state_changed = changed_reg;

endmodule

### hdl/audible_state_tracker.sv
// ----------------------------------------------------------------------------
// audible_state_tracker
// Tracks whether mixed output is silent, silent except music, or audible.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one stereo frame per beat with
// its command, sample time and first/last buffer marks. Command 3 clears all
// tracking state. Only the last frame of a mixed buffer yields a result beat
// on the output channel (out_valid / out_stall): the new state and a flag
// saying whether this buffer changed it.
// A frame is registered on entry and the result is registered on the way out.
// Throughput: one frame per cycle while the receiver does not stall; the state
// update for a frame is a single pass of compares and subtractions between
// the input and result registers. The user must write registers through
// cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
// Reset clears the tracking state and loads the register defaults; no pass
// over storage is needed. When the receiver stalls, the held result and one
// further frame are kept; in_stall then rises until the result is taken.
// ----------------------------------------------------------------------------
module audible_state_tracker #(
    parameter int TIME_BITS   = 48,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          cmd,
    input  logic signed [SAMPLE_BITS-1:0]       left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       right_sample,
    input  logic [TIME_BITS-1:0]                frame_time,
    input  logic                                first_frame,
    input  logic                                last_frame,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          audible_state,
    output logic                                state_changed,
    input  logic                                cfg_write,
    input  logic [ast_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ast_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ast_pkg::*;

    logic [MARGIN_BITS-1:0]        margin_reg;
    logic [MCF_BITS-1:0]           mcf_reg;
    logic                          advance;
    frame_ctrl_t                   ctrl;
    logic signed [SAMPLE_BITS-1:0] left_q, right_q;
    logic [TIME_BITS-1:0]          time_q;
    result_t                       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
            mcf_reg    <= MCF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAMPLE_MARGIN: margin_reg <= cfg_data[MARGIN_BITS-1:0];
                REG_MIN_CHANGE:    mcf_reg    <= cfg_data[MCF_BITS-1:0];
                default:           ;
            endcase
        end
    end

    ast_in_stage #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .frame_time   (frame_time),
        .first_frame  (first_frame),
        .last_frame   (last_frame),
        .advance      (advance),
        .ctrl         (ctrl),
        .left_q       (left_q),
        .right_q      (right_q),
        .time_q       (time_q)
    );

    ast_core #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .ctrl              (ctrl),
        .left_sample       (left_q),
        .right_sample      (right_q),
        .frame_time        (time_q),
        .sample_margin     (margin_reg),
        .min_change_frames (mcf_reg),
        .res               (res)
    );

    ast_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .audible_state (audible_state),
        .state_changed (state_changed),
        .advance       (advance)
    );

endmodule
